/* hw/rtl/sorted_table_insert_delete_macros.svh */
// assertion macros for the sorted table block
// no dependencies; included by modules that carry concurrent checks
// each macro expects signals named clk and rst_n in the including module
`ifndef SORTED_TABLE_INSERT_DELETE_MACROS_SVH
`define SORTED_TABLE_INSERT_DELETE_MACROS_SVH

// same-cycle implication, checked out of reset
`define STID_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication, checked out of reset
`define STID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* hw/rtl/stid_pkg.sv */
// shared types and codes for the sorted table block
// no dependencies; used by stid_cmp and sorted_table_insert_delete
`default_nettype none

package stid_pkg;

  // fixed field widths
  localparam int VAL_W  = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LIST   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LIST,
    S_INS,
    S_INS_LAST,
    S_DEL
  } state_t;

  // result of the shared compare unit
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

endpackage

`default_nettype wire

/* hw/rtl/stid_ram.sv */
// entry storage: one write port, one read port with registered read data
// no dependencies
`default_nettype none

module stid_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/stid_cmp.sv */
// shared signed compare unit used by the insert and delete walks
// depends on stid_pkg
`default_nettype none

module stid_cmp (
  input  wire logic signed [stid_pkg::VAL_W-1:0] entry,
  input  wire logic signed [stid_pkg::VAL_W-1:0] key,
  output stid_pkg::cmp_res_t                     res
);

  // one signed greater-than compare and one equality
  always_comb begin
    res.gt = (entry > key);
    res.eq = (entry == key);
  end

endmodule

`default_nettype wire

/* hw/rtl/sorted_table_insert_delete.sv */
// Sorted table of signed 32-bit values, ascending, duplicates allowed.
// Command channel: a transaction is taken at a clock edge with start high
// and busy low; in_command selects list, insert or delete, in_value is the
// key. Code 3 is dropped with no result.
// Result channel: out_valid marks each result for exactly one cycle; the
// receiver cannot stall it. out_last flags the final result of a command,
// out_entry_count gives the table size after the command.
// Command handling:
//   full/empty rejects: result in the cycle after the command, busy stays low.
//   list: one result per cycle from the first entry up, busy while the
//     entries are read out.
//   insert: walks down from the top, moving each entry larger than the
//     key up one slot, then writes the key into the freed slot; busy throughout.
//   delete: walks the whole table, busy throughout.
// A single compare unit and a one-read, one-write entry memory mean that
// one entry moves per cycle.
// Reset empties the table; no memory clearing pass is needed.
// Depends on stid_pkg, stid_ram, stid_cmp and the assertion macros header.
`default_nettype none
`include "sorted_table_insert_delete_macros.svh"

module sorted_table_insert_delete #(
  parameter int CAPACITY = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic        [stid_pkg::CMD_W-1:0]      in_command,
  input  wire logic signed [stid_pkg::VAL_W-1:0]      in_value,
  output logic                                        out_valid,
  output logic signed      [stid_pkg::VAL_W-1:0]      out_entry_value,
  output logic             [stid_pkg::STAT_W-1:0]     out_status,
  output logic                                        out_last,
  output logic             [stid_pkg::CNT_W-1:0]      out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  stid_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  logic signed [stid_pkg::VAL_W-1:0] key_r, key_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic signed [stid_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  logic [stid_pkg::STAT_W-1:0]       out_status_r, out_status_nxt;
  logic                              out_last_r, out_last_nxt;
  logic [stid_pkg::CNT_W-1:0]        out_count_r, out_count_nxt;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [stid_pkg::VAL_W-1:0] wr_data;
  logic [AW-1:0]              rd_addr;
  logic [stid_pkg::VAL_W-1:0] rd_data;
  stid_pkg::cmp_res_t         cmp;

  // entry memory
  stid_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (AW),
    .DATA_W (stid_pkg::VAL_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  // shared compare of the fetched entry against the key
  stid_cmp u_cmp (
    .entry (rd_data),
    .key   (key_r),
    .res   (cmp)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stid_pkg::S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  // sequencer: next state, memory control, results
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    key_nxt        = key_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = AW'(idx_r);
    wr_data        = rd_data;
    rd_addr        = '0;

    unique case (state_r)
      stid_pkg::S_IDLE: begin
        if (start) begin
          key_nxt = in_value;
          idx_nxt = '0;
          found_nxt = 1'b0;
          unique case (in_command)
            stid_pkg::CMD_LIST: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = stid_pkg::STAT_EMPTY;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt = stid_pkg::S_LIST;
              end
            end
            stid_pkg::CMD_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = stid_pkg::STAT_FULL;
                out_last_nxt   = 1'b1;
              end else if (count_r == '0) begin
                state_nxt = stid_pkg::S_INS_LAST;
              end else begin
                idx_nxt   = count_r;
                rd_addr   = AW'(count_r - CW'(1));
                state_nxt = stid_pkg::S_INS;
              end
            end
            stid_pkg::CMD_DELETE: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = stid_pkg::STAT_EMPTY;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt = stid_pkg::S_DEL;
              end
            end
            default: begin
              state_nxt = stid_pkg::S_IDLE;
            end
          endcase
        end
      end

      // emit one entry per cycle, prefetch the next
      stid_pkg::S_LIST: begin
        rd_addr        = AW'(idx_r + CW'(1));
        idx_nxt        = idx_r + CW'(1);
        out_valid_nxt  = 1'b1;
        out_value_nxt  = rd_data;
        out_status_nxt = stid_pkg::STAT_OK;
        out_last_nxt   = (idx_r == count_r - CW'(1));
        if (idx_r == count_r - CW'(1)) begin
          state_nxt = stid_pkg::S_IDLE;
        end
      end

      // walk down from the top, moving larger entries up one slot
      stid_pkg::S_INS: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx_r);
        rd_addr = AW'(idx_r - CW'(2));
        if (cmp.gt) begin
          wr_data = rd_data;
          idx_nxt = idx_r - CW'(1);
          if (idx_r == CW'(1)) begin
            state_nxt = stid_pkg::S_INS_LAST;
          end
        end else begin
          wr_data        = key_r;
          count_nxt      = count_r + CW'(1);
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = stid_pkg::STAT_OK;
          out_last_nxt   = 1'b1;
          state_nxt      = stid_pkg::S_IDLE;
        end
      end

      // key goes into the bottom slot
      stid_pkg::S_INS_LAST: begin
        wr_en          = 1'b1;
        wr_addr        = AW'(idx_r);
        wr_data        = key_r;
        count_nxt      = count_r + CW'(1);
        out_valid_nxt  = 1'b1;
        out_value_nxt  = '0;
        out_status_nxt = stid_pkg::STAT_OK;
        out_last_nxt   = 1'b1;
        state_nxt      = stid_pkg::S_IDLE;
      end

      // search for the first match, then pull later entries down one slot
      stid_pkg::S_DEL: begin
        rd_addr   = AW'(idx_r + CW'(1));
        wr_en     = found_r;
        wr_addr   = AW'(idx_r - CW'(1));
        wr_data   = rd_data;
        found_nxt = found_r | cmp.eq;
        idx_nxt   = idx_r + CW'(1);
        if (idx_r == count_r - CW'(1)) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = stid_pkg::S_IDLE;
          if (found_r | cmp.eq) begin
            count_nxt      = count_r - CW'(1);
            out_status_nxt = stid_pkg::STAT_OK;
          end else begin
            out_status_nxt = stid_pkg::STAT_NOT_FOUND;
          end
        end
      end

      default: begin
        state_nxt = stid_pkg::S_IDLE;
      end
    endcase

    out_count_nxt = stid_pkg::CNT_W'(count_nxt);
  end

  // port drive
  assign busy            = (state_r != stid_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_entry_value = out_value_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;
  assign out_entry_count = out_count_r;

  // checks
  `STID_ASSERT_NOW(a_count_in_range, 1'b1, count_r <= CW'(CAPACITY))
  `STID_ASSERT_NOW(a_write_only_busy, wr_en, busy)
  `STID_ASSERT_NOW(a_midlist_busy, out_valid && !out_last, busy)
  `STID_ASSERT_NEXT(a_full_reject,
      start && !busy && (in_command == stid_pkg::CMD_INSERT) && (count_r == CW'(CAPACITY)),
      out_valid && (out_status == stid_pkg::STAT_FULL) && $stable(count_r))

endmodule

`default_nettype wire
